// File: src/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants for the multi-alarm block
// Request codes, edit-item codes, value limits and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int REQ_W    = 2;
  localparam int LEVEL_W  = 2;
  localparam int ITEM_W   = 2;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int COUNT_W  = 10;
  localparam int SLOT_W   = 3;
  localparam int CFG_IDX_W = 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MODE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UP   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DOWN = 2'd3;

  // press length classes
  localparam logic [LEVEL_W-1:0] LEVEL_SHORT = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID   = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_LONG  = 2'd2;

  // edit items
  localparam logic [ITEM_W-1:0] ITEM_SELECT = 2'd0;
  localparam logic [ITEM_W-1:0] ITEM_ENABLE = 2'd1;
  localparam logic [ITEM_W-1:0] ITEM_HOUR   = 2'd2;
  localparam logic [ITEM_W-1:0] ITEM_MINUTE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LONG = 1'd1;

  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  localparam logic [COUNT_W-1:0]  REPEAT_MAX = 10'd1023;

  localparam logic [COUNT_W-1:0] REPEAT_MID_RESET  = 10'd500;
  localparam logic [COUNT_W-1:0] REPEAT_LONG_RESET = 10'd200;

  typedef struct packed {
    logic load_item;
    logic count_inc;
    logic count_clr;
    logic match;
    logic step;
    logic step_up;
    logic force_select;
    logic toggle_mode;
    logic load_out;
  } mas_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             edit_mode;
    logic             level_ge1;
    logic             fire_up;
    logic             fire_dn;
  } mas_stat_t;

endpackage

// File: src/mas_ctrl.sv
// ----------------------------------------------------------------------------
// mas_ctrl: sequencing controller
// Accepts one request, walks it through execute and, for ticks in set mode,
// repeat phases and hands the result to the output register.
// ----------------------------------------------------------------------------
module mas_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  mas_pkg::mas_stat_t stat,
  output mas_pkg::mas_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_UP   = 5'b00100,
    S_DN   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (stat.req)
          mas_pkg::REQ_TICK: begin
            cmd.count_inc = 1'b1;
            if (stat.edit_mode) begin
              state_nxt = S_UP;
            end else begin
              cmd.match = 1'b1;
            end
          end
          mas_pkg::REQ_MODE: begin
            cmd.count_clr   = 1'b1;
            cmd.toggle_mode = stat.level_ge1;
          end
          mas_pkg::REQ_UP: begin
            cmd.count_clr    = 1'b1;
            cmd.step         = 1'b1;
            cmd.step_up      = 1'b1;
            cmd.force_select = !stat.edit_mode;
          end
          mas_pkg::REQ_DOWN: begin
            cmd.count_clr = 1'b1;
            cmd.step      = stat.edit_mode;
          end
          default: ;
        endcase
      end
      S_UP: begin
        if (stat.fire_up) begin
          cmd.step      = 1'b1;
          cmd.step_up   = 1'b1;
          cmd.count_clr = 1'b1;
        end
        state_nxt = S_DN;
      end
      S_DN: begin
        if (stat.fire_dn) begin
          cmd.step      = 1'b1;
          cmd.count_clr = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: src/mas_dp.sv
// ----------------------------------------------------------------------------
// mas_dp: alarm datapath
// Holds the slots, selection, set-mode flag, repeat counter, interval
// registers and the result register; applies one command set per cycle.
// ----------------------------------------------------------------------------
module mas_dp #(
  parameter int NUM_SLOTS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mas_pkg::mas_cmd_t                   cmd,
  output mas_pkg::mas_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mas_pkg::COUNT_W-1:0]         cfg_wdata,
  input  logic [mas_pkg::REQ_W-1:0]           in_req_type,
  input  logic [mas_pkg::LEVEL_W-1:0]         in_press_level,
  input  logic                                in_up_held,
  input  logic                                in_down_held,
  input  logic [mas_pkg::ITEM_W-1:0]          in_edit_item,
  input  logic [mas_pkg::HOUR_W-1:0]          in_now_hour,
  input  logic [mas_pkg::MINUTE_W-1:0]        in_now_minute,
  output logic                                out_ring,
  output logic                                out_set_mode,
  output logic [mas_pkg::SLOT_W-1:0]          out_sel_slot,
  output logic [mas_pkg::HOUR_W-1:0]          out_sel_hour,
  output logic [mas_pkg::MINUTE_W-1:0]        out_sel_minute,
  output logic                                out_sel_enabled
);

  localparam int SELW = $clog2(NUM_SLOTS + 1);
  localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SELW-1:0] SEL_ONE  = SELW'(1);
  localparam logic [SELW-1:0] SEL_LAST = SELW'(NUM_SLOTS);

  // latched request
  logic [mas_pkg::REQ_W-1:0]    req_r;
  logic [mas_pkg::LEVEL_W-1:0]  level_r;
  logic                         up_held_r;
  logic                         down_held_r;
  logic [mas_pkg::ITEM_W-1:0]   item_r;
  logic [mas_pkg::HOUR_W-1:0]   now_hour_r;
  logic [mas_pkg::MINUTE_W-1:0] now_minute_r;

  // architectural state
  logic [mas_pkg::HOUR_W-1:0]   slot_hour_r   [NUM_SLOTS];
  logic [mas_pkg::MINUTE_W-1:0] slot_minute_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]         slot_enable_r, slot_enable_nxt;
  logic [SELW-1:0]              selected_r, selected_nxt;
  logic                         edit_mode_r, edit_mode_nxt;
  logic [mas_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         ring_r, ring_nxt;
  logic [mas_pkg::COUNT_W-1:0]  mid_r, long_r;

  // result register
  logic                         res_ring_r;
  logic                         res_mode_r;
  logic [mas_pkg::SLOT_W-1:0]   res_slot_r;
  logic [mas_pkg::HOUR_W-1:0]   res_hour_r;
  logic [mas_pkg::MINUTE_W-1:0] res_minute_r;
  logic                         res_enabled_r;

  logic [SELW-1:0]              sel_m1;
  logic [IDXW-1:0]              sel_idx;
  logic [SELW+2:0]              sel_ext;
  logic [mas_pkg::HOUR_W-1:0]   cur_hour, hour_nxt;
  logic [mas_pkg::MINUTE_W-1:0] cur_minute, minute_nxt;
  logic                         cur_enable, enable_nxt;
  logic                         slot_wr;
  logic [mas_pkg::ITEM_W-1:0]   step_item;
  logic                         lvl_fire;
  logic [NUM_SLOTS-1:0]         hit;

  assign sel_m1     = selected_r - SEL_ONE;
  assign sel_idx    = sel_m1[IDXW-1:0];
  assign sel_ext    = {3'b000, selected_r};
  assign cur_hour   = slot_hour_r[sel_idx];
  assign cur_minute = slot_minute_r[sel_idx];
  assign cur_enable = slot_enable_r[sel_idx];

  // repeat threshold check on the current count
  assign lvl_fire = ((level_r == mas_pkg::LEVEL_MID)  && (count_r >= mid_r)) ||
                    ((level_r == mas_pkg::LEVEL_LONG) && (count_r >= long_r));

  assign stat.req       = req_r;
  assign stat.edit_mode = edit_mode_r;
  assign stat.level_ge1 = (level_r != mas_pkg::LEVEL_SHORT);
  assign stat.fire_up   = up_held_r && lvl_fire;
  assign stat.fire_dn   = down_held_r && lvl_fire;

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit[k] = slot_enable_r[k] && (slot_hour_r[k] == now_hour_r) &&
               (slot_minute_r[k] == now_minute_r);
    end
  end

  // single step on the selected slot or the selection
  always_comb begin
    step_item    = cmd.force_select ? mas_pkg::ITEM_SELECT : item_r;
    selected_nxt = selected_r;
    hour_nxt     = cur_hour;
    minute_nxt   = cur_minute;
    enable_nxt   = cur_enable;
    slot_wr      = 1'b0;
    if (cmd.step) begin
      unique case (step_item)
        mas_pkg::ITEM_SELECT: begin
          if (cmd.step_up) begin
            selected_nxt = (selected_r >= SEL_LAST) ? SEL_ONE : selected_r + SEL_ONE;
          end else begin
            selected_nxt = (selected_r <= SEL_ONE) ? SEL_LAST : selected_r - SEL_ONE;
          end
        end
        mas_pkg::ITEM_ENABLE: begin
          slot_wr    = 1'b1;
          enable_nxt = !cur_enable;
          if (!cur_enable) begin
            hour_nxt   = now_hour_r;
            minute_nxt = now_minute_r;
          end
        end
        mas_pkg::ITEM_HOUR: begin
          slot_wr = 1'b1;
          if (cmd.step_up) begin
            hour_nxt = (cur_hour >= mas_pkg::HOUR_MAX) ? '0 : cur_hour + 1'b1;
          end else begin
            hour_nxt = (cur_hour == '0) ? mas_pkg::HOUR_MAX : cur_hour - 1'b1;
          end
        end
        mas_pkg::ITEM_MINUTE: begin
          slot_wr = 1'b1;
          if (cmd.step_up) begin
            minute_nxt = (cur_minute >= mas_pkg::MINUTE_MAX) ? '0 : cur_minute + 1'b1;
          end else begin
            minute_nxt = (cur_minute == '0) ? mas_pkg::MINUTE_MAX : cur_minute - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_enable_nxt = slot_enable_r;
    ring_nxt        = ring_r;
    count_nxt       = count_r;
    edit_mode_nxt   = edit_mode_r;
    if (cmd.load_item) begin
      ring_nxt = 1'b0;
    end
    if (cmd.match) begin
      slot_enable_nxt = slot_enable_r & ~hit;
      ring_nxt        = |hit;
    end
    if (slot_wr) begin
      slot_enable_nxt[sel_idx] = enable_nxt;
    end
    if (cmd.count_clr) begin
      count_nxt = '0;
    end else if (cmd.count_inc && (count_r != mas_pkg::REPEAT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.toggle_mode) begin
      edit_mode_nxt = !edit_mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        slot_hour_r[k]   <= '0;
        slot_minute_r[k] <= '0;
      end
      slot_enable_r <= '0;
      selected_r    <= SEL_ONE;
      edit_mode_r   <= 1'b0;
      count_r       <= '0;
      ring_r        <= 1'b0;
      mid_r         <= mas_pkg::REPEAT_MID_RESET;
      long_r        <= mas_pkg::REPEAT_LONG_RESET;
    end else begin
      if (slot_wr) begin
        slot_hour_r[sel_idx]   <= hour_nxt;
        slot_minute_r[sel_idx] <= minute_nxt;
      end
      slot_enable_r <= slot_enable_nxt;
      selected_r    <= selected_nxt;
      edit_mode_r   <= edit_mode_nxt;
      count_r       <= count_nxt;
      ring_r        <= ring_nxt;
      if (cfg_we && (cfg_index == mas_pkg::CFG_REPEAT_MID)) begin
        mid_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == mas_pkg::CFG_REPEAT_LONG)) begin
        long_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_r        <= in_req_type;
      level_r      <= in_press_level;
      up_held_r    <= in_up_held;
      down_held_r  <= in_down_held;
      item_r       <= in_edit_item;
      now_hour_r   <= in_now_hour;
      now_minute_r <= in_now_minute;
    end
    if (cmd.load_out) begin
      res_ring_r    <= ring_r;
      res_mode_r    <= edit_mode_r;
      res_slot_r    <= sel_ext[mas_pkg::SLOT_W-1:0];
      res_hour_r    <= cur_hour;
      res_minute_r  <= cur_minute;
      res_enabled_r <= cur_enable;
    end
  end

  assign out_ring        = res_ring_r;
  assign out_set_mode    = res_mode_r;
  assign out_sel_slot    = res_slot_r;
  assign out_sel_hour    = res_hour_r;
  assign out_sel_minute  = res_minute_r;
  assign out_sel_enabled = res_enabled_r;

endmodule

// File: src/multi_alarm_set_and_match.sv
// ----------------------------------------------------------------------------
// multi_alarm_set_and_match: five-slot alarm with set mode and time match
// Top level joining the sequencing controller and the alarm datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a millisecond
//   tick or a mode/up/down button release, plus the held buttons, press
//   class, edit item and the current time.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   request: ring, the set-mode flag and the selected slot's contents.
//   Configuration port (cfg_we/cfg_index/cfg_wdata) writes the mid and long
//   auto-repeat intervals; write only while no request is in flight.
//   Releases and ticks outside set mode take the execute phase only; ticks
//   in set mode also take the up-repeat and down-repeat phases, the
//   controller walking these phases in turn on one step unit.
//   A new request is taken only once the last is through; the input is taken
//   again as soon as the result moves into the output register.
//   Reset (synchronous, active low) clears all slots, selects slot 1, leaves
//   set mode, clears the repeat counter and restores intervals 500 and 200.
//   A stalled receiver holds the result in the output register; the next
//   request is still accepted and processed, then waits to hand over.
// ----------------------------------------------------------------------------
module multi_alarm_set_and_match #(
  parameter int NUM_SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mas_pkg::REQ_W-1:0]     in_req_type,
  input  logic [mas_pkg::LEVEL_W-1:0]   in_press_level,
  input  logic                          in_up_held,
  input  logic                          in_down_held,
  input  logic [mas_pkg::ITEM_W-1:0]    in_edit_item,
  input  logic [mas_pkg::HOUR_W-1:0]    in_now_hour,
  input  logic [mas_pkg::MINUTE_W-1:0]  in_now_minute,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ring,
  output logic                          out_set_mode,
  output logic [mas_pkg::SLOT_W-1:0]    out_sel_slot,
  output logic [mas_pkg::HOUR_W-1:0]    out_sel_hour,
  output logic [mas_pkg::MINUTE_W-1:0]  out_sel_minute,
  output logic                          out_sel_enabled,
  // configuration
  input  logic                          cfg_we,
  input  logic [mas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mas_pkg::COUNT_W-1:0]   cfg_wdata
);

  mas_pkg::mas_cmd_t  cmd;
  mas_pkg::mas_stat_t stat;

  // sequence each request: execute, then optional repeat phases, then hand off
  mas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slots, selection, counters and the result register
  mas_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_press_level  (in_press_level),
    .in_up_held      (in_up_held),
    .in_down_held    (in_down_held),
    .in_edit_item    (in_edit_item),
    .in_now_hour     (in_now_hour),
    .in_now_minute   (in_now_minute),
    .out_ring        (out_ring),
    .out_set_mode    (out_set_mode),
    .out_sel_slot    (out_sel_slot),
    .out_sel_hour    (out_sel_hour),
    .out_sel_minute  (out_sel_minute),
    .out_sel_enabled (out_sel_enabled)
  );

  // ring only comes from a match, which never runs in set mode
  a_ring_not_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ring |-> !out_set_mode)
    else $error("ring raised while in set mode");

  // one request at a time: the input closes right after an accept
  a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready held after accept");

  // no result is shown right after a reset edge
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
